// File: hw/rtl/guarded_slot_allocator_defines.svh
// ---------------------------------------------------------------------------
// Guarded slot allocator assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef GUARDED_SLOT_ALLOCATOR_DEFINES_SVH
`define GUARDED_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define GSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define GSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gsa_pkg.sv
// ---------------------------------------------------------------------------
// Guarded slot allocator package
// Sizes, codes and the command record passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

    localparam int SLOTS            = 64;
    localparam int QUARANTINE_DEPTH = 16;
    localparam int PAGE_BYTES       = 4096;
    localparam int CMD_QUEUE_DEPTH  = 2;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 13;
    localparam int MAXS_W   = 12;
    localparam int RATE_W   = 32;
    localparam int RNG_W    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int FC_W     = $clog2(SLOTS + 1);
    localparam int QH_W     = $clog2(QUARANTINE_DEPTH);
    localparam int QC_W     = $clog2(QUARANTINE_DEPTH + 1);
    localparam int PAGE_W   = $clog2(PAGE_BYTES);
    localparam int LIM_W    = PAGE_W + 1;
    localparam int STRIDE   = 3 * PAGE_BYTES;
    localparam int SPAN     = SLOTS * STRIDE;
    localparam int OFF_W    = $clog2(SPAN);
    localparam int QT_W     = OFF_W - PAGE_W;
    localparam int DIV3_S   = QT_W + 2;
    localparam int DIV3_K   = (2 ** DIV3_S) / 3 + 1;
    localparam int MAX_LIMIT = PAGE_BYTES - 32;
    localparam int CQ_W     = $clog2(CMD_QUEUE_DEPTH);
    localparam int CQC_W    = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam int MODC_W   = $clog2(RATE_W);

    localparam logic [RNG_W-1:0] WEYL_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [SIZE_W-1:0] DEFAULT_ALIGN = 13'd16;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 64;

    typedef enum logic [1:0] {
        REG_REGION_BASE = 2'd0,
        REG_MAX_SIZE    = 2'd1,
        REG_SAMPLE_RATE = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_FAULT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_NONE       = 2'd1,
        STS_NOT_REGION = 2'd2,
        STS_DOUBLE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_INUSE = 2'd1,
        SLOT_QUAR  = 2'd2
    } t_slot_st;

    typedef struct packed {
        t_op               op;
        logic              size_ok;
        logic              in_region;
        logic [SLOT_W-1:0] idx;
        logic [SIZE_W-1:0] sz;
        logic [SIZE_W-1:0] al;
        logic              fix;
    } t_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/gsa_front.sv
// ---------------------------------------------------------------------------
// Guarded slot allocator front end
// Takes requests, checks size and region, maps the address to a slot.
// ---------------------------------------------------------------------------
`default_nettype none

module gsa_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_op,
    input  wire logic [gsa_pkg::SIZE_W-1:0]  i_req_size,
    input  wire logic [gsa_pkg::SIZE_W-1:0]  i_alignment,
    input  wire logic [gsa_pkg::ADDR_W-1:0]  i_address,
    input  wire logic                        i_fix_up,
    input  wire logic [gsa_pkg::ADDR_W-1:0]  i_region_base,
    input  wire logic [gsa_pkg::MAXS_W-1:0]  i_max_size,
    input  wire logic                        i_q_full,
    output logic                             o_push,
    output gsa_pkg::t_cmd                    o_cmd
);

    logic                       r_v, n_v;
    logic [1:0]                 r_op;
    logic [gsa_pkg::SIZE_W-1:0] r_sz, r_al;
    logic [gsa_pkg::ADDR_W-1:0] r_addr;
    logic                       r_fix;

    logic                                   accept;
    logic [gsa_pkg::LIM_W-1:0]              eff_max;
    logic [gsa_pkg::ADDR_W-1:0]             off;
    logic [gsa_pkg::QT_W-1:0]               pg;
    logic [gsa_pkg::QT_W+gsa_pkg::DIV3_S-1:0] prod;

    assign o_stall = r_v && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_v && !i_q_full;

    always_comb begin
        n_v = r_v;
        if (accept) begin
            n_v = 1'b1;
        end else if (o_push) begin
            n_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_op;
            r_sz   <= i_req_size;
            r_al   <= i_alignment;
            r_addr <= i_address;
            r_fix  <= i_fix_up;
        end
    end

    always_comb begin
        if (i_max_size == '0 ||
            gsa_pkg::LIM_W'(i_max_size) > gsa_pkg::LIM_W'(gsa_pkg::MAX_LIMIT)) begin
            eff_max = gsa_pkg::LIM_W'(gsa_pkg::MAX_LIMIT);
        end else begin
            eff_max = gsa_pkg::LIM_W'(i_max_size);
        end
    end

    assign off  = r_addr - i_region_base;
    assign pg   = off[gsa_pkg::OFF_W-1:gsa_pkg::PAGE_W];
    assign prod = (gsa_pkg::QT_W+gsa_pkg::DIV3_S)'(pg) *
                  (gsa_pkg::QT_W+gsa_pkg::DIV3_S)'(gsa_pkg::DIV3_K);

    always_comb begin
        o_cmd.op        = gsa_pkg::t_op'(r_op);
        o_cmd.size_ok   = (r_sz != '0) &&
                          (gsa_pkg::LIM_W'(r_sz) <= eff_max);
        o_cmd.in_region = (r_addr >= i_region_base) &&
                          (off < gsa_pkg::ADDR_W'(gsa_pkg::SPAN));
        o_cmd.idx       = prod[gsa_pkg::DIV3_S +: gsa_pkg::SLOT_W];
        o_cmd.sz        = r_sz;
        o_cmd.al        = r_al;
        o_cmd.fix       = r_fix;
    end

endmodule

`default_nettype wire

// File: hw/rtl/gsa_queue.sv
// ---------------------------------------------------------------------------
// Guarded slot allocator command queue
// Short FIFO of classified requests between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module gsa_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  gsa_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output gsa_pkg::t_cmd      o_cmd
);

    gsa_pkg::t_cmd r_mem [gsa_pkg::CMD_QUEUE_DEPTH];
    logic [gsa_pkg::CQ_W-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [gsa_pkg::CQC_W-1:0] r_cnt, n_cnt;
    logic                      do_push, do_pop;

    assign o_full  = r_cnt == gsa_pkg::CQC_W'(gsa_pkg::CMD_QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == gsa_pkg::CQ_W'(gsa_pkg::CMD_QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == gsa_pkg::CQ_W'(gsa_pkg::CMD_QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gsa_back.sv
// ---------------------------------------------------------------------------
// Guarded slot allocator back end
// Sequencer over slot tables, free stack and quarantine ring; result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gsa_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [gsa_pkg::ADDR_W-1:0]  i_region_base,
    input  wire logic [gsa_pkg::RATE_W-1:0]  i_sample_rate,
    input  wire logic                        i_cmd_valid,
    input  gsa_pkg::t_cmd                    i_cmd,
    output logic                             o_cmd_pop,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [1:0]                       o_status,
    output logic [gsa_pkg::ADDR_W-1:0]       o_user_address,
    output logic [gsa_pkg::SLOT_W-1:0]       o_slot_index,
    output logic [gsa_pkg::SIZE_W-1:0]       o_block_size
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MOD    = 10'b00_0000_0010,
        S_ARD    = 10'b00_0000_0100,
        S_AADDR  = 10'b00_0000_1000,
        S_AWR    = 10'b00_0001_0000,
        S_FRD    = 10'b00_0010_0000,
        S_FEVICT = 10'b00_0100_0000,
        S_FENQ   = 10'b00_1000_0000,
        S_TRD    = 10'b01_0000_0000,
        S_RES    = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    gsa_pkg::t_cmd r_cmd, n_cmd;

    logic [gsa_pkg::SLOT_W-1:0] r_idx, n_idx, r_old, n_old;
    logic [gsa_pkg::ADDR_W-1:0] r_data, n_data;
    logic [gsa_pkg::RATE_W-1:0] r_phase, n_phase, r_num, n_num, r_rem, n_rem;
    logic [gsa_pkg::MODC_W-1:0] r_cnt, n_cnt;
    logic [gsa_pkg::RNG_W-1:0]  r_rng, n_rng;
    logic [gsa_pkg::FC_W-1:0]   r_fc, n_fc;
    logic [gsa_pkg::QH_W-1:0]   r_qhead, n_qhead;
    logic [gsa_pkg::QC_W-1:0]   r_qcnt, n_qcnt;

    gsa_pkg::t_status            r_res_st, n_res_st;
    logic [gsa_pkg::ADDR_W-1:0]  r_res_ua, n_res_ua;
    logic [gsa_pkg::SLOT_W-1:0]  r_res_si, n_res_si;
    logic [gsa_pkg::SIZE_W-1:0]  r_res_bs, n_res_bs;

    logic                        r_ov, n_ov;
    gsa_pkg::t_status            r_ost;
    logic [gsa_pkg::ADDR_W-1:0]  r_oua;
    logic [gsa_pkg::SLOT_W-1:0]  r_osi;
    logic [gsa_pkg::SIZE_W-1:0]  r_obs;
    logic                        out_load;

    gsa_pkg::t_slot_st           r_st_mem [gsa_pkg::SLOTS];
    logic [gsa_pkg::SLOTS-1:0]   r_st_vld;
    gsa_pkg::t_slot_st           r_st_rd;
    logic [gsa_pkg::ADDR_W-1:0]  r_ua_mem [gsa_pkg::SLOTS];
    logic [gsa_pkg::SIZE_W-1:0]  r_bs_mem [gsa_pkg::SLOTS];
    logic [gsa_pkg::ADDR_W-1:0]  r_ua_rd;
    logic [gsa_pkg::SIZE_W-1:0]  r_bs_rd;
    logic [gsa_pkg::SLOT_W-1:0]  r_stk_mem [gsa_pkg::SLOTS];
    logic [gsa_pkg::SLOTS-1:0]   r_stk_vld;
    logic [gsa_pkg::SLOT_W-1:0]  r_stk_rd;
    logic [gsa_pkg::SLOT_W-1:0]  r_ring [gsa_pkg::QUARANTINE_DEPTH];

    logic                        st_we;
    logic [gsa_pkg::SLOT_W-1:0]  st_wa, st_ra;
    gsa_pkg::t_slot_st           st_wd;
    logic                        tbl_we;
    logic [gsa_pkg::SLOT_W-1:0]  tbl_a;
    logic                        stk_we;
    logic [gsa_pkg::SLOT_W-1:0]  stk_wa, stk_ra, stk_wd;
    logic                        ring_we;
    logic [gsa_pkg::QH_W-1:0]    ring_wa;

    logic [gsa_pkg::FC_W-1:0]    fc_m1;
    logic [gsa_pkg::QH_W-1:0]    head_inc;
    logic [gsa_pkg::QC_W:0]      tail_sum;
    logic [gsa_pkg::QC_W:0]      tail_wrap;
    logic [gsa_pkg::RATE_W-1:0]  rate;
    logic [gsa_pkg::RATE_W:0]    rem_sh;
    logic [gsa_pkg::RATE_W-1:0]  rem_nx;
    logic [gsa_pkg::ADDR_W-1:0]  end_addr, mask, user;
    logic [gsa_pkg::SIZE_W-1:0]  align;

    assign fc_m1     = r_fc - 1'b1;
    assign head_inc  = (r_qhead == gsa_pkg::QH_W'(gsa_pkg::QUARANTINE_DEPTH - 1)) ?
                       '0 : r_qhead + 1'b1;
    assign tail_sum  = (gsa_pkg::QC_W+1)'(r_qhead) + (gsa_pkg::QC_W+1)'(r_qcnt);
    assign tail_wrap = (tail_sum >= (gsa_pkg::QC_W+1)'(gsa_pkg::QUARANTINE_DEPTH)) ?
                       tail_sum - (gsa_pkg::QC_W+1)'(gsa_pkg::QUARANTINE_DEPTH) : tail_sum;
    assign rate      = (i_sample_rate == '0) ? gsa_pkg::RATE_W'(1) : i_sample_rate;
    assign rem_sh    = {r_rem, r_num[gsa_pkg::RATE_W-1]};
    assign rem_nx    = (rem_sh >= {1'b0, rate}) ?
                       gsa_pkg::RATE_W'(rem_sh - {1'b0, rate}) : gsa_pkg::RATE_W'(rem_sh);
    assign align     = (r_cmd.al == '0) ? gsa_pkg::DEFAULT_ALIGN : r_cmd.al;
    assign end_addr  = r_data + gsa_pkg::ADDR_W'(gsa_pkg::PAGE_BYTES) -
                       gsa_pkg::ADDR_W'(r_cmd.sz);
    assign mask      = ~(gsa_pkg::ADDR_W'(align) - 1'b1);
    assign user      = r_rng[gsa_pkg::RNG_W-1] ? (end_addr & mask) : r_data;
    assign out_load  = (r_state == S_RES) && (!r_ov || !i_stall);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_old    = r_old;
        n_data   = r_data;
        n_phase  = r_phase;
        n_num    = r_num;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_rng    = r_rng;
        n_fc     = r_fc;
        n_qhead  = r_qhead;
        n_qcnt   = r_qcnt;
        n_res_st = r_res_st;
        n_res_ua = r_res_ua;
        n_res_si = r_res_si;
        n_res_bs = r_res_bs;
        o_cmd_pop = 1'b0;
        st_we    = 1'b0;
        st_wa    = r_cmd.idx;
        st_wd    = gsa_pkg::SLOT_QUAR;
        st_ra    = i_cmd.idx;
        tbl_we   = 1'b0;
        tbl_a    = (r_state == S_IDLE) ? i_cmd.idx : r_idx;
        stk_we   = 1'b0;
        stk_wa   = r_fc[gsa_pkg::SLOT_W-1:0];
        stk_wd   = r_old;
        stk_ra   = fc_m1[gsa_pkg::SLOT_W-1:0];
        ring_we  = 1'b0;
        ring_wa  = tail_wrap[gsa_pkg::QH_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_res_st  = gsa_pkg::STS_NONE;
                    n_res_ua  = '0;
                    n_res_si  = '0;
                    n_res_bs  = '0;
                    n_state   = S_RES;
                    unique case (i_cmd.op)
                        gsa_pkg::OP_SAMPLE: begin
                            if (i_cmd.size_ok) begin
                                n_num   = r_phase;
                                n_phase = r_phase + 1'b1;
                                n_rem   = '0;
                                n_cnt   = '1;
                                n_state = S_MOD;
                            end
                        end
                        gsa_pkg::OP_ALLOC: begin
                            if (i_cmd.size_ok && (r_fc != '0 || r_qcnt != '0)) begin
                                if (r_fc != '0) begin
                                    n_fc    = fc_m1;
                                    n_state = S_ARD;
                                end else begin
                                    n_idx   = r_ring[r_qhead];
                                    n_qhead = head_inc;
                                    n_qcnt  = r_qcnt - 1'b1;
                                    n_state = S_AADDR;
                                end
                            end
                        end
                        gsa_pkg::OP_FREE: begin
                            if (!i_cmd.in_region) begin
                                n_res_st = gsa_pkg::STS_NOT_REGION;
                            end else begin
                                n_state = S_FRD;
                            end
                        end
                        gsa_pkg::OP_FAULT: begin
                            if (!i_cmd.in_region) begin
                                n_res_st = gsa_pkg::STS_NOT_REGION;
                            end else begin
                                n_idx   = i_cmd.idx;
                                n_state = S_TRD;
                            end
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_MOD: begin
                n_rem = rem_nx;
                n_num = {r_num[gsa_pkg::RATE_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_res_st = (rem_nx == '0) ? gsa_pkg::STS_OK : gsa_pkg::STS_NONE;
                    n_state  = S_RES;
                end
            end
            S_ARD: begin
                n_idx   = r_stk_rd;
                n_state = S_AADDR;
            end
            S_AADDR: begin
                n_data  = i_region_base +
                          gsa_pkg::ADDR_W'({r_idx, gsa_pkg::PAGE_W'(0)}) +
                          gsa_pkg::ADDR_W'({r_idx, gsa_pkg::PAGE_W'(0), 1'b0}) +
                          gsa_pkg::ADDR_W'(gsa_pkg::PAGE_BYTES);
                n_state = S_AWR;
            end
            S_AWR: begin
                tbl_we   = 1'b1;
                st_we    = 1'b1;
                st_wa    = r_idx;
                st_wd    = gsa_pkg::SLOT_INUSE;
                n_rng    = r_rng + gsa_pkg::WEYL_STEP;
                n_res_st = gsa_pkg::STS_OK;
                n_res_ua = user;
                n_res_si = r_idx;
                n_res_bs = r_cmd.sz;
                n_state  = S_RES;
            end
            S_FRD: begin
                n_res_si = r_cmd.idx;
                if (r_st_rd == gsa_pkg::SLOT_QUAR) begin
                    n_res_st = gsa_pkg::STS_DOUBLE;
                    n_state  = S_RES;
                end else begin
                    st_we = 1'b1;
                    if (r_qcnt >= gsa_pkg::QC_W'(gsa_pkg::QUARANTINE_DEPTH)) begin
                        n_old   = r_ring[r_qhead];
                        n_qhead = head_inc;
                        n_qcnt  = r_qcnt - 1'b1;
                        n_state = S_FEVICT;
                    end else begin
                        n_state = S_FENQ;
                    end
                end
            end
            S_FEVICT: begin
                st_we = 1'b1;
                st_wa = r_old;
                st_wd = gsa_pkg::SLOT_FREE;
                if (r_fc < gsa_pkg::FC_W'(gsa_pkg::SLOTS)) begin
                    stk_we = 1'b1;
                    n_fc   = r_fc + 1'b1;
                end
                n_state = S_FENQ;
            end
            S_FENQ: begin
                ring_we  = 1'b1;
                n_qcnt   = r_qcnt + 1'b1;
                n_res_st = gsa_pkg::STS_OK;
                n_state  = S_RES;
            end
            S_TRD: begin
                n_res_st = gsa_pkg::STS_OK;
                n_res_ua = r_ua_rd;
                n_res_bs = r_bs_rd;
                n_res_si = r_cmd.idx;
                if (r_cmd.fix && r_st_rd == gsa_pkg::SLOT_QUAR) begin
                    st_we = 1'b1;
                    st_wd = gsa_pkg::SLOT_INUSE;
                end
                n_state = S_RES;
            end
            S_RES: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ov = r_ov;
        if (out_load) begin
            n_ov = 1'b1;
        end else if (!i_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_rng    <= '0;
            r_fc     <= gsa_pkg::FC_W'(gsa_pkg::SLOTS);
            r_qhead  <= '0;
            r_qcnt   <= '0;
            r_ov     <= 1'b0;
            r_st_vld <= '0;
            r_stk_vld <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_rng   <= n_rng;
            r_fc    <= n_fc;
            r_qhead <= n_qhead;
            r_qcnt  <= n_qcnt;
            r_ov    <= n_ov;
            if (st_we) begin
                r_st_vld[st_wa] <= 1'b1;
            end
            if (stk_we) begin
                r_stk_vld[stk_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_old    <= n_old;
        r_data   <= n_data;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_res_st <= n_res_st;
        r_res_ua <= n_res_ua;
        r_res_si <= n_res_si;
        r_res_bs <= n_res_bs;
        if (out_load) begin
            r_ost <= r_res_st;
            r_oua <= r_res_ua;
            r_osi <= r_res_si;
            r_obs <= r_res_bs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_wa] <= st_wd;
        end
        r_st_rd <= r_st_vld[st_ra] ? r_st_mem[st_ra] : gsa_pkg::SLOT_FREE;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_ua_mem[tbl_a] <= user;
            r_bs_mem[tbl_a] <= r_cmd.sz;
        end
        r_ua_rd <= r_ua_mem[tbl_a];
        r_bs_rd <= r_bs_mem[tbl_a];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_rd <= r_stk_vld[stk_ra] ? r_stk_mem[stk_ra] : stk_ra;
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_wa] <= r_cmd.idx;
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_ost;
    assign o_user_address = r_oua;
    assign o_slot_index   = r_osi;
    assign o_block_size   = r_obs;

endmodule

`default_nettype wire

// File: hw/rtl/guarded_slot_allocator.sv
// ---------------------------------------------------------------------------
// Guarded slot allocator
// Manages 64 guarded slots with a free stack and a quarantine ring. Requests
// are checked and mapped to a slot by the front end, queued, then carried
// out by a sequencer over the slot tables. A free takes an extra eviction
// step when the ring is full; declined or outside-region requests go straight
// to the result. An accepted sample query runs a one-bit-per-cycle remainder
// step over the 32-bit phase.
// Up to two requests wait between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module guarded_slot_allocator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [1:0]                   i_op,
    input  wire logic [gsa_pkg::SIZE_W-1:0]   i_req_size,
    input  wire logic [gsa_pkg::SIZE_W-1:0]   i_alignment,
    input  wire logic [gsa_pkg::ADDR_W-1:0]   i_address,
    input  wire logic                         i_fix_up,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_status,
    output logic [gsa_pkg::ADDR_W-1:0]        o_user_address,
    output logic [gsa_pkg::SLOT_W-1:0]        o_slot_index,
    output logic [gsa_pkg::SIZE_W-1:0]        o_block_size,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gsa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [gsa_pkg::PDATA_W-1:0]  pwdata,
    output logic [gsa_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [gsa_pkg::ADDR_W-1:0] r_region_base;
    logic [gsa_pkg::MAXS_W-1:0] r_max_size;
    logic [gsa_pkg::RATE_W-1:0] r_sample_rate;
    gsa_pkg::t_reg_idx          reg_idx;
    logic                       cfg_wr;

    gsa_pkg::t_cmd f_cmd, q_cmd;
    logic          f_push, q_full, q_valid, q_pop;

    assign pready  = 1'b1;
    assign reg_idx = gsa_pkg::t_reg_idx'(paddr[gsa_pkg::PADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= '0;
            r_max_size    <= gsa_pkg::MAXS_W'(gsa_pkg::MAX_LIMIT);
            r_sample_rate <= gsa_pkg::RATE_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                gsa_pkg::REG_REGION_BASE: r_region_base <= pwdata[gsa_pkg::ADDR_W-1:0];
                gsa_pkg::REG_MAX_SIZE:    r_max_size    <= pwdata[gsa_pkg::MAXS_W-1:0];
                gsa_pkg::REG_SAMPLE_RATE: r_sample_rate <= pwdata[gsa_pkg::RATE_W-1:0];
                default: begin
                    r_sample_rate <= r_sample_rate;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gsa_pkg::REG_REGION_BASE: prdata = gsa_pkg::PDATA_W'(r_region_base);
            gsa_pkg::REG_MAX_SIZE:    prdata = gsa_pkg::PDATA_W'(r_max_size);
            gsa_pkg::REG_SAMPLE_RATE: prdata = gsa_pkg::PDATA_W'(r_sample_rate);
            default:                  prdata = '0;
        endcase
    end

    gsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_req_size    (i_req_size),
        .i_alignment   (i_alignment),
        .i_address     (i_address),
        .i_fix_up      (i_fix_up),
        .i_region_base (r_region_base),
        .i_max_size    (r_max_size),
        .i_q_full      (q_full),
        .o_push        (f_push),
        .o_cmd         (f_cmd)
    );

    gsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    gsa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_region_base  (r_region_base),
        .i_sample_rate  (r_sample_rate),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_cmd_pop      (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_user_address (o_user_address),
        .o_slot_index   (o_slot_index),
        .o_block_size   (o_block_size)
    );

endmodule

`default_nettype wire

// File: hw/rtl/gsa_checker.sv
// ---------------------------------------------------------------------------
// Guarded slot allocator port checker
// Watches the top-level ports for result consistency over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "guarded_slot_allocator_defines.svh"

module gsa_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic [1:0]                   o_status,
    input wire logic [gsa_pkg::ADDR_W-1:0]   o_user_address,
    input wire logic [gsa_pkg::SLOT_W-1:0]   o_slot_index,
    input wire logic [gsa_pkg::SIZE_W-1:0]   o_block_size
);

    `GSA_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_status) && $stable(o_user_address) &&
        $stable(o_slot_index) && $stable(o_block_size),
        "stalled result changed")
    `GSA_ASSERT_NOW(a_outside_empty, i_clk, i_rst_n,
        o_valid && o_status == gsa_pkg::STS_NOT_REGION,
        o_user_address == '0 && o_slot_index == '0 && o_block_size == '0,
        "outside-region result carries data")
    `GSA_ASSERT_NOW(a_double_free, i_clk, i_rst_n,
        o_valid && o_status == gsa_pkg::STS_DOUBLE,
        o_user_address == '0 && o_block_size == '0,
        "double-free result carries block data")

endmodule

bind guarded_slot_allocator gsa_checker u_gsa_checker (.*);

`default_nettype wire
